[rtl/plucked_string_voice_defines.svh]
// Assertion macros for the plucked string voice.
// Included by the RTL files that carry concurrent assertions; needs a clk and rst_n in scope.
`ifndef PLUCKED_STRING_VOICE_DEFINES_SVH
`define PLUCKED_STRING_VOICE_DEFINES_SVH

// Assertion checked on every edge once reset is released.
`define PSV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion checked on every edge, reset included.
`define PSV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/psv_pkg.sv]
// Package for the plucked string voice: sizes, register indexes, sequencer states
// and saturation helpers. No dependencies.
package psv_pkg;

  localparam int BUF_DEPTH  = 2048;
  localparam int ADDR_W     = 11;
  localparam int FILL_W     = ADDR_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int WIDE_W     = SAMPLE_W + 8;
  localparam int ACC_W      = 46;
  localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

  localparam logic [16:0] HP_GAIN_RST = 17'd65322;
  localparam logic [16:0] HP_POLE_RST = 17'd65109;
  localparam logic [16:0] UNITY_Q16   = 17'd65536;
  localparam logic [15:0] VEL_MAX     = 16'd32768;

  typedef enum logic [2:0] {
    REG_LOOP_COEF_B = 3'd0,
    REG_LOOP_COEF_A = 3'd1,
    REG_FB_GAIN     = 3'd2,
    REG_HP_GAIN     = 3'd3,
    REG_HP_POLE     = 3'd4,
    REG_NOISE_SEED  = 3'd5
  } psv_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MIX_A, S_MIX_B, S_GAIN, S_EXC,
    S_RD0, S_RD1, S_RD2, S_IL, S_IP,
    S_LP1, S_LP2, S_LP3, S_FB, S_YM, S_YW,
    S_HP1, S_HP2, S_HP3, S_OUT
  } psv_state_t;

  function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd8388607;
    lo = -32'sd8388608;
    if (v > hi) return hi[WIDE_W-1:0];
    else if (v < lo) return lo[WIDE_W-1:0];
    else return v[WIDE_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd32767;
    lo = -32'sd32768;
    if (v > hi) return hi[SAMPLE_W-1:0];
    else if (v < lo) return lo[SAMPLE_W-1:0];
    else return v[SAMPLE_W-1:0];
  endfunction

endpackage

[rtl/plucked_string_voice.sv]
// Top level of the plucked string voice: sequencer, shared multiplier and both delay lines.
// Depends on psv_pkg and plucked_string_voice_defines.svh.
//
// A Karplus-Strong string voice. An input beat with in_tuser set starts a note: it latches
// the loop delay and three quarters of the velocity and restarts the excitation burst; it
// leaves the sequencer idle and gives no output beat. Any other input beat renders one
// sample and gives exactly one output beat. A render beat passes through a chain of
// sequencer states on its way to the output register, because every product of the
// excitation mix, both interpolated delay reads, the loop lowpass, the feedback gain and
// the DC blocker runs one after another through a single 18 x 25 multiplier with a 46-bit
// accumulator, and both delay lines are read through one registered port each. in_tready
// is high only while the sequencer is idle; a finished sample waits in the output register
// and the next beat can be accepted while it does. Both delay lines read as zero after
// reset: a fill count marks which entries have been written since, so no clearing pass is
// needed. Configuration writes are always accepted and must only be issued while the voice
// is idle; writing the noise seed also reloads the noise generator (zero loads one).
`include "plucked_string_voice_defines.svh"

module plucked_string_voice
  import psv_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [0] kind: 0 renders a sample, 1 starts a note
  input  logic         in_tuser,
  // [26:0] note_delay, [42:27] note_velocity, [58:43] excitation_samples,
  // [82:59] phase_step, [99:83] brightness, [126:100] pluck_offset,
  // [142:127] feedback_in, [143] zero
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] sample_out
  output logic [15:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  // Configuration registers.
  logic signed [16:0] coef_b_r, coef_a_r, hp_pole_r;
  logic [16:0]        fb_gain_r, hp_gain_r;
  logic [31:0]        lfsr_r;

  // Note and voice state.
  logic [26:0]        loop_delay_r;
  logic [15:0]        note_gain_r;
  logic [23:0]        tri_phase_r;
  logic [15:0]        since_note_r;
  logic [ADDR_W-1:0]  wp_r;
  logic [FILL_W-1:0]  fill_r;
  logic signed [15:0] lp_prev_in_r;
  logic signed [23:0] lp_prev_out_r, hp_prev_in_r, hp_prev_out_r;

  // Per-sample working registers.
  logic               excite_r;
  logic [23:0]        step_r;
  logic [16:0]        bright_r;
  logic [26:0]        pluck_r;
  logic signed [15:0] fb_in_r;
  logic signed [17:0] exc_r;
  logic signed [15:0] lx0_r, lx1_r, px0_r, px1_r;
  logic signed [15:0] interp_r, pinterp_r;
  logic signed [23:0] y_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic               out_valid_r;
  logic [15:0]        out_data_r;

  psv_state_t state_r, state_nxt;

  // Delay line memories with registered reads.
  logic signed [15:0] loop_mem [BUF_DEPTH];
  logic signed [15:0] pluck_mem [BUF_DEPTH];
  logic signed [15:0] loop_rd_r, pluck_rd_r;
  logic               loop_rv_r, pluck_rv_r;
  logic [ADDR_W-1:0]  loop_addr, pluck_addr;
  logic               mem_we;
  logic signed [15:0] loop_wd, pluck_wd;

  logic in_acc, cfg_acc;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_acc    = cfg_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Read positions: write position minus a Q11.16 delay, wrapping around the line.
  logic [26:0] lpos, ppos;
  assign lpos = {wp_r, 16'd0} - loop_delay_r;
  assign ppos = {wp_r, 16'd0} - pluck_r;

  // Triangle from the phase, scaled to Q1.15 with floor rounding.
  logic signed [26:0] tri_full;
  logic signed [17:0] tri_val;
  always_comb begin
    if (tri_phase_r < 24'h40_0000) begin
      tri_full = $signed({1'b0, tri_phase_r, 2'b00});
    end else if (tri_phase_r < 24'hC0_0000) begin
      tri_full = 27'sd33554432 - $signed({1'b0, tri_phase_r, 2'b00});
    end else begin
      tri_full = $signed({1'b0, tri_phase_r, 2'b00} - 27'h400_0000);
    end
  end
  assign tri_val = tri_full[26:9];

  // Next noise word and the noise sample taken from it.
  logic [31:0]        lfsr_step;
  logic signed [15:0] noise_val;
  assign lfsr_step = lfsr_r[0] ? ({1'b0, lfsr_r[31:1]} ^ LFSR_MASK) : {1'b0, lfsr_r[31:1]};
  assign noise_val = {~lfsr_r[31], lfsr_r[30:16]};

  // External feedback at 13/131072.
  logic signed [19:0] fb13;
  assign fb13 = ({{4{fb_in_r[15]}}, fb_in_r} <<< 3) + ({{4{fb_in_r[15]}}, fb_in_r} <<< 2)
              + {{4{fb_in_r[15]}}, fb_in_r};

  // The shared multiplier.
  logic signed [17:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [42:0] prod;
  logic signed [ACC_W-1:0] prod_x;
  assign prod   = mul_a * mul_b;
  assign prod_x = {{(ACC_W-43){prod[42]}}, prod};

  logic signed [29:0] acc_sh16;
  assign acc_sh16 = acc_r[45:16];

  logic signed [31:0] y_sum;
  logic signed [23:0] y_val, filt_val, hp_val;
  assign y_sum = {{14{exc_r[17]}}, exc_r} + {{2{acc_sh16[29]}}, acc_sh16}
               - {{16{pinterp_r[15]}}, pinterp_r} + {{29{fb13[19]}}, fb13[19:17]};
  assign y_val    = sat_wide(y_sum);
  assign filt_val = sat_wide({{2{acc_sh16[29]}}, acc_sh16});
  assign hp_val   = filt_val;

  logic signed [16:0] ldiff, pdiff;
  assign ldiff = {lx1_r[15], lx1_r} - {lx0_r[15], lx0_r};
  assign pdiff = {px1_r[15], px1_r} - {px0_r[15], px0_r};

  // Sequencer: next state, multiplier operands and accumulator.
  always_comb begin
    state_nxt  = state_r;
    mul_a      = '0;
    mul_b      = '0;
    acc_nxt    = acc_r;
    loop_addr  = lpos[26:16];
    pluck_addr = ppos[26:16];
    mem_we     = 1'b0;
    loop_wd    = sat_sample({{8{y_val[23]}}, y_val});
    pluck_wd   = sat_sample({{14{exc_r[17]}}, exc_r});
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !in_tuser) begin
          state_nxt = (since_note_r <= in_tdata[58:43]) ? S_MIX_A : S_RD0;
        end
      end
      S_MIX_A: begin
        mul_a = $signed({1'b0, UNITY_Q16 - bright_r});
        mul_b = {{7{tri_val[17]}}, tri_val};
        acc_nxt = prod_x;
        state_nxt = S_MIX_B;
      end
      S_MIX_B: begin
        mul_a = $signed({1'b0, bright_r});
        mul_b = {{9{noise_val[15]}}, noise_val};
        acc_nxt = acc_r + prod_x;
        state_nxt = S_GAIN;
      end
      S_GAIN: begin
        mul_a = $signed({2'b00, note_gain_r});
        mul_b = {{7{acc_r[33]}}, acc_r[33:16]};
        acc_nxt = prod_x;
        state_nxt = S_EXC;
      end
      S_EXC: state_nxt = S_RD0;
      S_RD0: state_nxt = S_RD1;
      S_RD1: begin
        loop_addr  = lpos[26:16] + 1'b1;
        pluck_addr = ppos[26:16] + 1'b1;
        state_nxt  = S_RD2;
      end
      S_RD2: state_nxt = S_IL;
      S_IL: begin
        mul_a = $signed({2'b00, lpos[15:0]});
        mul_b = {{8{ldiff[16]}}, ldiff};
        acc_nxt = prod_x;
        state_nxt = S_IP;
      end
      S_IP: begin
        mul_a = $signed({2'b00, ppos[15:0]});
        mul_b = {{8{pdiff[16]}}, pdiff};
        acc_nxt = prod_x;
        state_nxt = S_LP1;
      end
      S_LP1: begin
        mul_a = {coef_b_r[16], coef_b_r};
        mul_b = {{9{interp_r[15]}}, interp_r};
        acc_nxt = prod_x;
        state_nxt = S_LP2;
      end
      S_LP2: begin
        mul_a = {coef_b_r[16], coef_b_r};
        mul_b = {{9{lp_prev_in_r[15]}}, lp_prev_in_r};
        acc_nxt = acc_r + prod_x;
        state_nxt = S_LP3;
      end
      S_LP3: begin
        mul_a = {coef_a_r[16], coef_a_r};
        mul_b = {lp_prev_out_r[23], lp_prev_out_r};
        acc_nxt = acc_r + prod_x;
        state_nxt = S_FB;
      end
      S_FB: state_nxt = S_YM;
      S_YM: begin
        mul_a = $signed({1'b0, (fb_gain_r > UNITY_Q16) ? UNITY_Q16 : fb_gain_r});
        mul_b = {lp_prev_out_r[23], lp_prev_out_r};
        acc_nxt = prod_x;
        state_nxt = S_YW;
      end
      S_YW: begin
        loop_addr  = wp_r;
        pluck_addr = wp_r;
        mem_we     = 1'b1;
        state_nxt  = S_HP1;
      end
      S_HP1: begin
        mul_a = $signed({1'b0, (hp_gain_r > UNITY_Q16) ? UNITY_Q16 : hp_gain_r});
        mul_b = {y_r[23], y_r};
        acc_nxt = prod_x;
        state_nxt = S_HP2;
      end
      S_HP2: begin
        mul_a = $signed({1'b0, (hp_gain_r > UNITY_Q16) ? UNITY_Q16 : hp_gain_r});
        mul_b = {hp_prev_in_r[23], hp_prev_in_r};
        acc_nxt = acc_r - prod_x;
        state_nxt = S_HP3;
      end
      S_HP3: begin
        mul_a = {hp_pole_r[16], hp_pole_r};
        mul_b = {hp_prev_out_r[23], hp_prev_out_r};
        acc_nxt = acc_r + prod_x;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Delay line ports; an entry at or beyond the fill count has never been written.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      loop_mem[wp_r]  <= loop_wd;
      pluck_mem[wp_r] <= pluck_wd;
    end
    loop_rd_r  <= loop_mem[loop_addr];
    pluck_rd_r <= pluck_mem[pluck_addr];
    loop_rv_r  <= ({1'b0, loop_addr} < fill_r);
    pluck_rv_r <= ({1'b0, pluck_addr} < fill_r);
  end

  // Configuration, note state and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_b_r      <= '0;
      coef_a_r      <= '0;
      fb_gain_r     <= '0;
      hp_gain_r     <= HP_GAIN_RST;
      hp_pole_r     <= HP_POLE_RST;
      lfsr_r        <= 32'd1;
      loop_delay_r  <= '0;
      note_gain_r   <= '0;
      tri_phase_r   <= '0;
      since_note_r  <= '0;
      wp_r          <= '0;
      fill_r        <= '0;
      lp_prev_in_r  <= '0;
      lp_prev_out_r <= '0;
      hp_prev_in_r  <= '0;
      hp_prev_out_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          REG_LOOP_COEF_B: coef_b_r  <= cfg_data[16:0];
          REG_LOOP_COEF_A: coef_a_r  <= cfg_data[16:0];
          REG_FB_GAIN:     fb_gain_r <= cfg_data[16:0];
          REG_HP_GAIN:     hp_gain_r <= cfg_data[16:0];
          REG_HP_POLE:     hp_pole_r <= cfg_data[16:0];
          REG_NOISE_SEED:  lfsr_r    <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end else if (state_r == S_MIX_A) begin
        lfsr_r <= lfsr_step;
      end

      // The finished-sample stage below reloads the register on its own.
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_tuser) begin
            loop_delay_r <= in_tdata[26:0];
            note_gain_r  <= 16'(({2'b00, (in_tdata[42:27] > VEL_MAX) ? VEL_MAX
                                             : in_tdata[42:27]} * 18'd3) >> 2);
            tri_phase_r  <= '0;
            since_note_r <= '0;
          end
        end
        S_FB: begin
          lp_prev_in_r  <= interp_r;
          lp_prev_out_r <= filt_val;
        end
        S_YW: begin
          tri_phase_r <= tri_phase_r + step_r;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            hp_prev_in_r  <= y_r;
            hp_prev_out_r <= hp_val;
            out_valid_r   <= 1'b1;
            wp_r          <= wp_r + 1'b1;
            if (fill_r < FILL_W'(BUF_DEPTH)) begin
              fill_r <= fill_r + 1'b1;
            end
            if (since_note_r != 16'hFFFF) begin
              since_note_r <= since_note_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Per-sample datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc && !in_tuser) begin
          excite_r <= (since_note_r <= in_tdata[58:43]);
          step_r   <= in_tdata[82:59];
          bright_r <= (in_tdata[99:83] > UNITY_Q16) ? UNITY_Q16 : in_tdata[99:83];
          pluck_r  <= in_tdata[126:100];
          fb_in_r  <= in_tdata[142:127];
          exc_r    <= '0;
        end
      end
      S_EXC: exc_r <= acc_r[32:15];
      S_RD1: begin
        lx0_r <= loop_rv_r ? loop_rd_r : '0;
        px0_r <= pluck_rv_r ? pluck_rd_r : '0;
      end
      S_RD2: begin
        lx1_r <= loop_rv_r ? loop_rd_r : '0;
        px1_r <= pluck_rv_r ? pluck_rd_r : '0;
      end
      S_IP:  interp_r  <= lx0_r + acc_sh16[15:0];
      S_LP1: pinterp_r <= px0_r + acc_sh16[15:0];
      S_YW:  y_r <= y_val;
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_r <= sat_sample({{8{hp_val[23]}}, hp_val});
        end
      end
      default: ;
    endcase
  end

  `PSV_ASSERT(a_out_held, (state_r == S_OUT && out_valid_r && !out_tready) |=> (state_r == S_OUT), "finished sample left while the output register was full")
  `PSV_ASSERT(a_out_shown, (state_r == S_OUT && (!out_valid_r || out_tready)) |=> out_valid_r, "finished sample not presented")
  `PSV_ASSERT(a_note_idle, (in_acc && in_tuser) |=> (state_r == S_IDLE && in_tready), "note start left the sequencer busy")
  `PSV_ASSERT(a_fill_bound, fill_r <= FILL_W'(BUF_DEPTH), "fill count beyond the delay line")
  `PSV_ASSERT(a_excite_path, (state_r == S_EXC) |-> excite_r, "excitation stage entered without a burst")

endmodule
